/* hw/rtl/wtsc_pkg.sv */
// Wave-table sound channel: shared constants and the packing widths of the stream beats.
// No dependencies. Used by wave_table_sound_channel.
package wtsc_pkg;

    localparam logic [15:0] ADDR_DAC_ENABLE  = 16'hFF1A;
    localparam logic [15:0] ADDR_PERIOD_LOW  = 16'hFF1D;
    localparam logic [15:0] ADDR_PERIOD_HIGH = 16'hFF1E;
    localparam logic [11:0] ADDR_WAVE_PAGE   = 12'hFF3;

    localparam int WAVE_BYTES  = 16;
    localparam int WAVE_AW     = $clog2(WAVE_BYTES);
    localparam int POS_W       = WAVE_AW + 1;
    localparam int COUNT_W     = 14;
    localparam int CALC_W      = 16;
    localparam int PERIOD_W    = 11;

    localparam logic signed [CALC_W-1:0] PERIOD_SPAN = 16'sd2048;
    localparam logic signed [CALC_W-1:0] COUNT_MIN   = -16'sd8192;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic
    {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

endpackage

/* hw/rtl/wave_table_sound_channel.sv */
// Wave-table sound channel top level: control registers, 16-byte wave RAM and output register.
// Depends on wtsc_pkg.
// Path: an accepted beat passes the RAM read register, then the output register, to m_axis.
// Throughput: one beat per cycle unless m_axis stalls; RAM: one write, one read per cycle.
// Reset: rst_n clears the channel registers, the RAM valid bits and both pipeline valids;
// RAM entries not yet written read as zero, so no clearing pass is needed.
module wave_table_sound_channel
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: tick_cycles[5:0], address[21:6], write_data[29:22], zero pad
    input  logic [wtsc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: mode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: sample[3:0], channel_on[4], write_claimed[5], zero pad
    output logic [wtsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    logic [5:0]  in_cycles;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    wtsc_pkg::mode_t in_mode;

    logic accept;
    logic advance;

    logic                                running_reg, running_next;
    logic [wtsc_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic signed [wtsc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                          dac_reg, dac_next;
    logic [7:0]                          plow_reg, plow_next;
    logic [7:0]                          phigh_reg, phigh_next;
    logic                                claimed;
    logic                                wave_wr;
    logic [wtsc_pkg::WAVE_AW-1:0]        wave_idx;
    logic [wtsc_pkg::WAVE_AW-1:0]        rd_addr;

    logic [wtsc_pkg::PERIOD_W-1:0]       period;
    logic signed [wtsc_pkg::CALC_W-1:0]  reload;
    logic signed [wtsc_pkg::CALC_W-1:0]  diff;
    logic signed [wtsc_pkg::CALC_W-1:0]  wrapped;

    logic [7:0]                          wave_mem [wtsc_pkg::WAVE_BYTES];
    logic [wtsc_pkg::WAVE_BYTES-1:0]     wave_valid_reg;

    logic       p_valid_reg;
    logic       p_odd_reg;
    logic       p_run_reg;
    logic       p_claim_reg;
    logic [7:0] rd_data_reg;
    logic       rd_valid_reg;

    logic                              out_valid_reg;
    logic [wtsc_pkg::OUT_TDATA_W-1:0]  out_data_reg;
    logic [3:0]                        nibble;

    assign in_cycles = s_axis_tdata[5:0];
    assign in_addr   = s_axis_tdata[21:6];
    assign in_wdata  = s_axis_tdata[29:22];
    assign in_mode   = wtsc_pkg::mode_t'(s_axis_tuser);

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !p_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        running_next = running_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        dac_next     = dac_reg;
        plow_next    = plow_reg;
        phigh_next   = phigh_reg;
        claimed      = 1'b0;
        wave_wr      = 1'b0;
        wave_idx     = in_addr[wtsc_pkg::WAVE_AW-1:0];
        period       = '0;
        reload       = '0;
        diff         = '0;
        wrapped      = '0;

        unique case (in_mode)
            wtsc_pkg::MODE_TICK:
            begin
                period  = {phigh_reg[2:0], plow_reg};
                reload  = (wtsc_pkg::PERIOD_SPAN
                           - $signed({{(wtsc_pkg::CALC_W-wtsc_pkg::PERIOD_W){1'b0}}, period}))
                          <<< 1;
                diff    = $signed({{(wtsc_pkg::CALC_W-wtsc_pkg::COUNT_W){count_reg[13]}},
                                   count_reg})
                          - $signed({{(wtsc_pkg::CALC_W-6){1'b0}}, in_cycles});
                wrapped = reload + diff;
                if (running_reg)
                begin
                    if (diff <= 0)
                    begin
                        pos_next = pos_reg + 1'b1;
                        if (wrapped < wtsc_pkg::COUNT_MIN)
                            count_next = wtsc_pkg::COUNT_MIN[wtsc_pkg::COUNT_W-1:0];
                        else
                            count_next = wrapped[wtsc_pkg::COUNT_W-1:0];
                    end
                    else
                    begin
                        count_next = diff[wtsc_pkg::COUNT_W-1:0];
                    end
                end
            end
            wtsc_pkg::MODE_WRITE:
            begin
                if (in_addr == wtsc_pkg::ADDR_DAC_ENABLE)
                begin
                    dac_next     = in_wdata;
                    running_next = in_wdata[7];
                    claimed      = 1'b1;
                end
                else if (in_addr == wtsc_pkg::ADDR_PERIOD_LOW)
                begin
                    plow_next = in_wdata;
                end
                else if (in_addr == wtsc_pkg::ADDR_PERIOD_HIGH)
                begin
                    phigh_next = in_wdata;
                    claimed    = 1'b1;
                    if (in_wdata[7])
                    begin
                        // trigger reload uses the new period
                        period       = {in_wdata[2:0], plow_reg};
                        reload       = (wtsc_pkg::PERIOD_SPAN
                                       - $signed({{(wtsc_pkg::CALC_W-wtsc_pkg::PERIOD_W){1'b0}},
                                                  period})) <<< 1;
                        running_next = 1'b1;
                        pos_next     = '0;
                        count_next   = reload[wtsc_pkg::COUNT_W-1:0];
                    end
                end
                else if (in_addr[15:4] == wtsc_pkg::ADDR_WAVE_PAGE)
                begin
                    wave_wr = 1'b1;
                end
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    assign rd_addr = pos_next[wtsc_pkg::POS_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            pos_reg        <= '0;
            count_reg      <= '0;
            dac_reg        <= '0;
            plow_reg       <= '0;
            phigh_reg      <= '0;
            wave_valid_reg <= '0;
            p_valid_reg    <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                running_reg  <= running_next;
                pos_reg      <= pos_next;
                count_reg    <= count_next;
                dac_reg      <= dac_next;
                plow_reg     <= plow_next;
                phigh_reg    <= phigh_next;
                if (wave_wr)
                    wave_valid_reg[wave_idx] <= 1'b1;
                rd_valid_reg <= wave_valid_reg[rd_addr] || (wave_wr && wave_idx == rd_addr);
            end
            if (accept)
                p_valid_reg <= 1'b1;
            else if (advance)
                p_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= p_valid_reg;
        end
    end

    // wave RAM: one write, one registered read; same-entry write forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (wave_wr)
                wave_mem[wave_idx] <= in_wdata;
            if (wave_wr && wave_idx == rd_addr)
                rd_data_reg <= in_wdata;
            else
                rd_data_reg <= wave_mem[rd_addr];
            p_odd_reg   <= pos_next[0];
            p_run_reg   <= running_next;
            p_claim_reg <= claimed;
        end
    end

    always_comb
    begin
        if (!p_run_reg || !rd_valid_reg)
            nibble = 4'd0;
        else if (p_odd_reg)
            nibble = rd_data_reg[3:0];
        else
            nibble = rd_data_reg[7:4];
    end

    always_ff @(posedge clk)
    begin
        if (advance && p_valid_reg)
            out_data_reg <= {2'b00, p_claim_reg, p_run_reg, nibble};
    end

endmodule
